[rtl/fds_pkg.sv]
// Package for the frame delta smoother: payload structs, sizes, register
// indexes and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package fds_pkg;

  // Field widths
  localparam int DELTA_W = 7;
  localparam int RATIO_W = 15;
  localparam int TIME_W  = 32;
  localparam int FPS_W   = 16;

  // History sizing
  localparam int HIST_DEPTH = 8;
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
  localparam int SUM_W      = DELTA_W + HIST_AW;

  // Mean divider: two quotient bits per step
  localparam int DIV_STEPS = (SUM_W + 1) / 2;
  localparam int DIVD_W    = 2 * DIV_STEPS;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  // Ratio: floor(d * 1024 / 5) == (d * 52429) >> 8 for every 7-bit d
  localparam int RECIP_W     = 16;
  localparam int RECIP_FIFTH = 52429;
  localparam int RATIO_SHIFT = 8;
  localparam int PROD_W      = DELTA_W + RECIP_W;
  localparam int RATIO_RESET = 4096;
  localparam int RATIO_MAX   = 26214;

  // Pull-back of last timestamp applies for an excess below this
  localparam int PULL_LIMIT = 5;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAME_PAUSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FPS_WINDOW = 2'd2;

  localparam logic [DELTA_W-1:0] MAX_DELTA_RESET  = 7'd100;
  localparam logic [FPS_W-1:0]   FPS_WINDOW_RESET = 16'd1000;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_RESET  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] timestamp_ms;
  } fds_in_t;

  typedef struct packed {
    logic [DELTA_W-1:0] delta_ms;
    logic [RATIO_W-1:0] delta_ratio;
    logic [TIME_W-1:0]  game_time_ms;
    logic [FPS_W-1:0]   frames_per_second;
  } fds_out_t;

  typedef struct packed {
    logic load;      // capture the request payload
    logic calc;      // clamp delta, update history, start divider
    logic div_step;  // two divider iterations
    logic fin;       // apply mean to timing state
    logic rst_item;  // timing reset request
    logic emit;      // move result into output register
  } fds_cmd_t;

  typedef struct packed {
    logic div_last;
  } fds_status_t;

endpackage

`default_nettype wire

[rtl/frame_delta_smoother_fps_counter.sv]
// Top level of the frame delta smoother with frame-rate counter.
// Depends on fds_pkg, fds_ctrl and fds_datapath.
//
//   channel  signals                          direction
//   -------  -------------------------------  ---------
//   in       in_valid, in_stall, in_data      request in (op, timestamp_ms)
//   out      out_valid, out_stall, out_data   result out, one per request
//   cfg      cfg_we, cfg_index, cfg_data      register write, no read-back
//
// A frame update goes from acceptance to the result register in these steps:
// capture, clamp and history update, the mean divider (two quotient bits per
// cycle over the 10-bit history sum), apply the mean, load the output. A
// timing reset request captures, applies the timing reset and loads the output.
// Reset (rst, synchronous) clears the timing state except the delta ratio;
// the history contents are not cleared and are tracked by the fill count.
// A stalled result holds in the output register; the next request may be
// accepted and worked on meanwhile, and waits to load until the result leaves.
`default_nettype none

module frame_delta_smoother_fps_counter (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  fds_pkg::fds_in_t              in_data,
  output logic                          out_valid,
  input  wire                           out_stall,
  output fds_pkg::fds_out_t             out_data,
  input  wire                           cfg_we,
  input  wire [fds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [fds_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fds_pkg::*;

  fds_cmd_t    cmd;
  fds_status_t status;
  fds_out_t    result;
  logic        out_free;

  // Output register is free when empty or when its result leaves this cycle
  assign out_free = !out_valid || !out_stall;

  fds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .item_op  (in_data.op),
    .out_free (out_free),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  fds_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .result    (result)
  );

  // Output register: load on emit, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

[rtl/fds_ctrl.sv]
// Controller for the frame delta smoother: sequences one request at a time.
// Depends on fds_pkg.
`default_nettype none

module fds_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  wire                  item_op,
  input  wire                  out_free,
  input  fds_pkg::fds_status_t status,
  output logic                 in_stall,
  output fds_pkg::fds_cmd_t    cmd
);
  import fds_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_FIN,
    S_RST,
    S_OUT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (item_op == OP_RESET) ? S_RST : S_CALC;
          end
        end
        S_CALC: state <= S_DIV;
        S_DIV: begin
          if (status.div_last) begin
            state <= S_FIN;
          end
        end
        S_FIN:  state <= S_OUT;
        S_RST:  state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.calc     = (state == S_CALC);
    cmd.div_step = (state == S_DIV);
    cmd.fin      = (state == S_FIN);
    cmd.rst_item = (state == S_RST);
    cmd.emit     = (state == S_OUT) && out_free;
  end

endmodule

`default_nettype wire

[rtl/fds_datapath.sv]
// Datapath for the frame delta smoother: registers, delta history, mean
// divider, timing and frame-rate state. Depends on fds_pkg.
`default_nettype none

module fds_datapath (
  input  wire                        clk,
  input  wire                        rst,
  input  fds_pkg::fds_cmd_t          cmd,
  input  fds_pkg::fds_in_t           in_data,
  input  wire                        cfg_we,
  input  wire [fds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [fds_pkg::CFG_DATA_W-1:0] cfg_data,
  output fds_pkg::fds_status_t       status,
  output fds_pkg::fds_out_t          result
);
  import fds_pkg::*;

  // Configuration
  logic [DELTA_W-1:0] max_delta;
  logic               paused;
  logic [FPS_W-1:0]   fps_window;

  // Timing state
  logic [DELTA_W-1:0] hist [HIST_DEPTH];
  logic [FILL_W-1:0]  fill;
  logic [SUM_W-1:0]   sum;
  logic [HIST_AW-1:0] head;
  logic [TIME_W-1:0]  last_time;
  logic [DELTA_W-1:0] smoothed;
  logic [TIME_W-1:0]  game_time;
  logic [TIME_W-1:0]  deadline;
  logic [FPS_W-1:0]   frame_count;
  logic [FPS_W-1:0]   frame_rate;
  logic [RATIO_W-1:0] ratio;

  // Per-request working registers
  logic [TIME_W-1:0]  ts;
  logic [DELTA_W-1:0] raw;
  logic [DIVD_W-1:0]  dividend;
  logic [DIVD_W-1:0]  quo;
  logic [FILL_W-1:0]  rem;
  logic [DCNT_W-1:0]  div_cnt;

  // History update
  logic [TIME_W-1:0]  delta_full;
  logic [DELTA_W-1:0] raw_next;
  logic               hist_full;
  logic [SUM_W-1:0]   sum_next;
  logic [FILL_W-1:0]  fill_next;
  logic [HIST_AW-1:0] head_next;

  always_comb begin
    delta_full = ts - last_time;
    raw_next   = (delta_full > TIME_W'(max_delta)) ? max_delta : delta_full[DELTA_W-1:0];
    hist_full  = (fill == FILL_W'(HIST_DEPTH));
    sum_next   = sum - (hist_full ? SUM_W'(hist[head]) : '0) + SUM_W'(raw_next);
    fill_next  = hist_full ? fill : fill + 1'b1;
    head_next  = (head == HIST_AW'(HIST_DEPTH - 1)) ? '0 : head + 1'b1;
  end

  // Divider step: two restoring iterations against the fill count
  logic [FILL_W-1:0] rem_next;
  logic [1:0]        qbits;

  always_comb begin
    logic [FILL_W:0]   trial;
    logic [FILL_W-1:0] r;
    r     = rem;
    qbits = '0;
    trial = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {r, dividend[DIVD_W-1-i]};
      if (trial >= {1'b0, fill}) begin
        trial     = trial - {1'b0, fill};
        qbits[1-i] = 1'b1;
      end
      r = trial[FILL_W-1:0];
    end
    rem_next = r;
  end

  assign status.div_last = (div_cnt == DCNT_W'(1));

  // Finish: mean, ratio, pull-back of last timestamp, windowing
  logic [DELTA_W-1:0] mean;
  logic [DELTA_W:0]   gap;
  logic               pull;
  logic [PROD_W-1:0]  prod;
  logic               roll;

  always_comb begin
    mean = quo[DELTA_W-1:0];
    gap  = {1'b0, raw} - {1'b0, mean};
    pull = (raw > mean) && (gap < (DELTA_W+1)'(PULL_LIMIT));
    prod = PROD_W'(mean) * PROD_W'(RECIP_FIFTH);
    roll = (deadline < ts);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_delta   <= MAX_DELTA_RESET;
      paused      <= 1'b0;
      fps_window  <= FPS_WINDOW_RESET;
      fill        <= '0;
      sum         <= '0;
      head        <= '0;
      last_time   <= '0;
      smoothed    <= '0;
      game_time   <= '0;
      deadline    <= '0;
      frame_count <= '0;
      frame_rate  <= '0;
      div_cnt     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_DELTA:  max_delta  <= cfg_data[DELTA_W-1:0];
          CFG_GAME_PAUSE: paused     <= cfg_data[0];
          CFG_FPS_WINDOW: fps_window <= cfg_data[FPS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.calc) begin
        sum     <= sum_next;
        fill    <= fill_next;
        head    <= head_next;
        div_cnt <= DCNT_W'(DIV_STEPS);
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt - 1'b1;
      end
      if (cmd.fin) begin
        smoothed  <= mean;
        last_time <= pull ? ts - TIME_W'(gap) : ts;
        if (!paused) begin
          game_time <= game_time + TIME_W'(mean);
        end
        if (roll) begin
          deadline    <= ts + TIME_W'(fps_window);
          frame_rate  <= frame_count;
          frame_count <= FPS_W'(1);
        end else if (frame_count != '1) begin
          frame_count <= frame_count + 1'b1;
        end
      end
      if (cmd.rst_item) begin
        last_time   <= ts;
        frame_count <= '0;
        frame_rate  <= '0;
        deadline    <= '0;
        paused      <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ts <= in_data.timestamp_ms;
    end
    if (cmd.calc) begin
      hist[head] <= raw_next;
      raw        <= raw_next;
      dividend   <= DIVD_W'(sum_next);
      quo        <= '0;
      rem        <= '0;
    end
    if (cmd.div_step) begin
      dividend <= dividend << 2;
      quo      <= {quo[DIVD_W-3:0], qbits};
      rem      <= rem_next;
    end
    if (cmd.fin) begin
      ratio <= prod[RATIO_SHIFT +: RATIO_W];
    end
    if (cmd.rst_item) begin
      ratio <= RATIO_W'(RATIO_RESET);
    end
  end

  always_comb begin
    result.delta_ms          = smoothed;
    result.delta_ratio       = ratio;
    result.game_time_ms      = game_time;
    result.frames_per_second = frame_rate;
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(HIST_DEPTH))
    else $error("history fill exceeds depth");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> (div_cnt == '0))
    else $error("mean used before divider finished");

  a_calc_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.calc |=> (fill != '0))
    else $error("divider started with zero fill");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (result.delta_ratio <= RATIO_W'(RATIO_MAX)))
    else $error("delta ratio out of range");
`endif

endmodule

`default_nettype wire
